[rtl/ring_buffer_running_average_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the ring buffer running average core
// Clocked property wrappers; defining NO_ASSERTIONS compiles them away.
// ----------------------------------------------------------------------------
`ifndef RING_BUFFER_RUNNING_AVERAGE_CORE_ASSERT_SVH
`define RING_BUFFER_RUNNING_AVERAGE_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Condition holds at every edge outside reset
`define RBAVG_ASSERT(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define RBAVG_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle
`define RBAVG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define RBAVG_ASSERT(label, clk, rst_n, cond, msg)
`define RBAVG_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define RBAVG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

[rtl/rbavg_pkg.sv]
// ----------------------------------------------------------------------------
// rbavg_pkg
// Shared types and constants of the ring buffer running average core.
// ----------------------------------------------------------------------------
package rbavg_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int DATA_W        = 32;
    localparam int INDEX_W       = 4;

    localparam logic signed [DATA_W-1:0] EMPTY_MARK = -32'sd1000;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_POP   = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    typedef struct packed {
        logic [1:0]               opcode;
        logic signed [DATA_W-1:0] sample;
    } cmd_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] popped_value;
        logic signed [DATA_W-1:0] newest_value;
        logic [INDEX_W-1:0]       newest_index;
        logic signed [DATA_W-1:0] mean_value;
        logic                     mean_valid;
    } res_t;

endpackage

[rtl/rbavg_ram.sv]
// ----------------------------------------------------------------------------
// rbavg_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module rbavg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/ring_buffer_running_average_core.sv]
// ----------------------------------------------------------------------------
// ring_buffer_running_average_core
// Ring of DEPTH signed samples with a running sum, count and truncating mean.
// ----------------------------------------------------------------------------
// Commands: add stores a sample at the write position and advances it; pop
// steps the position back and returns that entry (it stays stored); query
// (and the unused opcode) changes nothing. Each command gives one result with
// the newest entry, its index (low 4 bits) and the mean of all entries other
// than the empty marker -1000. After reset the block sweeps the sample RAM to
// the marker, one entry per cycle, before cmd_ready rises. A command then
// goes from transfer through the RAM lookup, a setup step and the divider to
// the result: the mean comes from a one-bit-per-cycle restoring divider over
// the SUM_W-bit running sum, and pop needs a second RAM read. With no live
// entry the divider is skipped. cmd_ready rises together with res_valid when
// the result is loaded; if the previous result is still waiting, the new
// one is held back until that one is taken. A finished result waits in the
// output register while the next command is taken.
// ----------------------------------------------------------------------------
`include "ring_buffer_running_average_core_assert.svh"

module ring_buffer_running_average_core #(
    parameter int DEPTH = rbavg_pkg::DEPTH_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_ready,
    input  rbavg_pkg::cmd_t cmd,
    output logic            res_valid,
    input  logic            res_ready,
    output rbavg_pkg::res_t res
);

    import rbavg_pkg::*;

    localparam int AW     = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = DATA_W + AW + 1;
    localparam int STEP_W = $clog2(SUM_W);

    localparam logic [AW-1:0]     LAST_POS  = AW'(DEPTH - 1);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_LOOK2,
        ST_SETUP,
        ST_DIV,
        ST_DONE
    } state_t;

    function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] p);
        return (p == '0) ? LAST_POS : p - AW'(1);
    endfunction

    state_t                    state_reg, state_next;
    logic [AW-1:0]             clr_reg, clr_next;
    logic [AW-1:0]             wp_reg, wp_next;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [1:0]                op_reg, op_next;
    logic signed [DATA_W-1:0]  sample_reg, sample_next;
    logic signed [DATA_W-1:0]  popped_reg, popped_next;
    logic signed [DATA_W-1:0]  newest_reg, newest_next;
    logic [AW-1:0]             idx_reg, idx_next;
    logic                      neg_reg, neg_next;
    logic                      mvalid_reg, mvalid_next;
    logic [SUM_W-1:0]          quo_reg, quo_next;
    logic [CNT_W-1:0]          rem_reg, rem_next;
    logic [STEP_W-1:0]         step_reg, step_next;
    res_t                      res_reg, res_next;
    logic                      res_valid_reg, res_valid_next;

    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    logic [DATA_W-1:0]         ram_wdata;
    logic [AW-1:0]             ram_raddr;
    logic [DATA_W-1:0]         ram_rdata;

    logic [AW-1:0]             wp_prev;
    logic [AW-1:0]             wp_prev2;
    logic signed [DATA_W-1:0]  old_entry;
    logic [CNT_W:0]            trial;
    logic [SUM_W-1:0]          mean_full;

    assign wp_prev   = ring_prev(wp_reg);
    assign wp_prev2  = ring_prev(wp_prev);
    assign old_entry = signed'(ram_rdata);
    assign trial     = {rem_reg, quo_reg[SUM_W-1]};
    assign mean_full = neg_reg ? (SUM_W'(0) - quo_reg) : quo_reg;

    assign cmd_ready = (state_reg == ST_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    rbavg_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        wp_next        = wp_reg;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        op_next        = op_reg;
        sample_next    = sample_reg;
        popped_next    = popped_reg;
        newest_next    = newest_reg;
        idx_next       = idx_reg;
        neg_next       = neg_reg;
        mvalid_next    = mvalid_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !res_ready;

        ram_we    = 1'b0;
        ram_waddr = wp_reg;
        ram_wdata = sample_reg;
        ram_raddr = wp_prev;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = EMPTY_MARK;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == LAST_POS)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                // add reads the entry it overwrites, the others the newest one
                ram_raddr = (cmd.opcode == OP_ADD) ? wp_reg : wp_prev;
                if (cmd_valid)
                begin
                    op_next     = cmd.opcode;
                    sample_next = cmd.sample;
                    state_next  = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                popped_next = '0;
                state_next  = ST_SETUP;
                case (op_reg)
                    OP_ADD:
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = wp_reg;
                        ram_wdata = sample_reg;
                        sum_next  = sum_reg
                                  - ((old_entry != EMPTY_MARK) ? SUM_W'(old_entry) : '0)
                                  + ((sample_reg != EMPTY_MARK) ? SUM_W'(sample_reg) : '0);
                        cnt_next  = cnt_reg
                                  - ((old_entry != EMPTY_MARK) ? CNT_W'(1) : '0)
                                  + ((sample_reg != EMPTY_MARK) ? CNT_W'(1) : '0);
                        wp_next     = (wp_reg == LAST_POS) ? '0 : wp_reg + AW'(1);
                        newest_next = sample_reg;
                        idx_next    = wp_reg;
                    end
                    OP_POP:
                    begin
                        popped_next = old_entry;
                        wp_next     = wp_prev;
                        ram_raddr   = wp_prev2;
                        idx_next    = wp_prev2;
                        state_next  = ST_LOOK2;
                    end
                    default:
                    begin
                        newest_next = old_entry;
                        idx_next    = wp_prev;
                    end
                endcase
            end
            ST_LOOK2:
            begin
                newest_next = old_entry;
                state_next  = ST_SETUP;
            end
            ST_SETUP:
            begin
                rem_next  = '0;
                step_next = '0;
                if (cnt_reg == '0)
                begin
                    neg_next    = 1'b0;
                    quo_next    = '0;
                    mvalid_next = 1'b0;
                    state_next  = ST_DONE;
                end
                else
                begin
                    neg_next    = sum_reg[SUM_W-1];
                    quo_next    = sum_reg[SUM_W-1] ? unsigned'(-sum_reg) : unsigned'(sum_reg);
                    mvalid_next = 1'b1;
                    state_next  = ST_DIV;
                end
            end
            ST_DIV:
            begin
                // restoring division of |sum| by count, one quotient bit a cycle
                if (trial >= {1'b0, cnt_reg})
                begin
                    rem_next = CNT_W'(trial - {1'b0, cnt_reg});
                    quo_next = {quo_reg[SUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[CNT_W-1:0];
                    quo_next = {quo_reg[SUM_W-2:0], 1'b0};
                end
                step_next = step_reg + STEP_W'(1);
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    res_next.popped_value = popped_reg;
                    res_next.newest_value = newest_reg;
                    res_next.newest_index = INDEX_W'(idx_reg);
                    res_next.mean_value   = signed'(mean_full[DATA_W-1:0]);
                    res_next.mean_valid   = mvalid_reg;
                    res_valid_next        = 1'b1;
                    state_next            = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            wp_reg        <= '0;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            op_reg        <= OP_QUERY;
            sample_reg    <= '0;
            popped_reg    <= '0;
            newest_reg    <= '0;
            idx_reg       <= '0;
            neg_reg       <= 1'b0;
            mvalid_reg    <= 1'b0;
            quo_reg       <= '0;
            rem_reg       <= '0;
            step_reg      <= '0;
            res_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            wp_reg        <= wp_next;
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            op_reg        <= op_next;
            sample_reg    <= sample_next;
            popped_reg    <= popped_next;
            newest_reg    <= newest_next;
            idx_reg       <= idx_next;
            neg_reg       <= neg_next;
            mvalid_reg    <= mvalid_next;
            quo_reg       <= quo_next;
            rem_reg       <= rem_next;
            step_reg      <= step_next;
            res_reg       <= res_next;
            res_valid_reg <= res_valid_next;
        end
    end

    `RBAVG_ASSERT(a_cnt_range, clk, rst_n, cnt_reg <= CNT_W'(DEPTH), "valid count above depth")
    `RBAVG_ASSERT(a_wp_range, clk, rst_n, wp_reg <= LAST_POS, "write position out of ring")
    `RBAVG_ASSERT_IMPL(a_empty_sum, clk, rst_n, cnt_reg == '0, sum_reg == '0, "sum with no entries")
    `RBAVG_ASSERT_NEXT(a_take_look, clk, rst_n, cmd_valid && cmd_ready, state_reg == ST_LOOK, "no lookup")

endmodule
